>>> hw/rtl/eidm_pkg.sv
// shared types and constants for the entity id allocator with mask query
// no dependencies; imported by the allocator, its free fifo and the bench files
`default_nettype none

package eidm_pkg;

    localparam int ID_W     = 6;
    localparam int MASK_W   = 64;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        K_CREATE  = 3'd0,
        K_DESTROY = 3'd1,
        K_WRITE   = 3'd2,
        K_READ    = 3'd3,
        K_QUERY   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD      = 3'd2,
        ST_NOMATCH  = 3'd3,
        ST_QFULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_READ,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/eidm_free_fifo.sv
// fifo of freed entity ids, held in a synchronous memory with registered read
// depends on eidm_pkg
`default_nettype none

module eidm_free_fifo
    import eidm_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fifo_ctrl_t       ctrl,
    input  wire logic [ID_W-1:0]  push_id,
    output logic      [ID_W-1:0]  pop_id,
    output fifo_stat_t            stat
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [ID_W-1:0]  mem [CAPACITY];
    logic [ID_W-1:0]  rd_data_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next  = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
        if (ctrl.push)
        begin
            tail_next  = (tail_reg == PTR_W'(CAPACITY - 1)) ? '0 : tail_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[tail_reg] <= push_id;
        if (ctrl.pop)
            rd_data_reg <= mem[head_reg];
    end

    assign pop_id     = rd_data_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(CAPACITY));

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> !stat.full)
        else $error("push into full free fifo");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> !stat.empty)
        else $error("pop from empty free fifo");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("free fifo count beyond capacity");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/entity_id_allocator_mask_query.sv
// words for a fresh create, table full, destroy, write and a bad entity come in the cycle after
//   acceptance, busy stays low; free-list create and read pass through S_POP or S_READ, busy high there
// throughput: one request a cycle for single-word kinds, each request ends before the next; the
//   receiver cannot stall. query: busy high for the whole scan in S_SCAN, one
//   mask read a cycle, a match is held until the next match or the scan end, last word after busy
// reset clears the fsm, counters and free list pointers; memories are not cleared, never read past
`default_nettype none

module entity_id_allocator_mask_query
    import eidm_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int MASK_BITS = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [KIND_W-1:0]  kind,
    input  wire logic [ID_W-1:0]    entity,
    input  wire logic [MASK_W-1:0]  mask,
    output logic                    strobe,
    output logic [ID_W-1:0]         entity_id,
    output logic [MASK_W-1:0]       mask_value,
    output logic [STATUS_W-1:0]     status,
    output logic                    last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  issued_count_reg, issued_count_next;
    logic              accept;
    logic              id_ok;
    logic              scan_done;

    // request context
    logic [ID_W-1:0]       req_id_reg, req_id_next;
    logic [MASK_BITS-1:0]  req_mask_reg, req_mask_next;

    // query scan pipeline: read index, compare slot, pending match
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_id_reg, pend_id_next;

    // output word
    logic              strobe_reg, strobe_next;
    logic [ID_W-1:0]   oid_reg, oid_next;
    logic [MASK_W-1:0] omask_reg, omask_next;
    status_t           ostat_reg, ostat_next;
    logic              olast_reg, olast_next;

    // mask store ports
    logic [MASK_BITS-1:0] mask_mem [CAPACITY];
    logic                 ms_we;
    logic [IDX_W-1:0]     ms_waddr;
    logic [MASK_BITS-1:0] ms_wdata;
    logic                 ms_re;
    logic [IDX_W-1:0]     ms_raddr;
    logic [MASK_BITS-1:0] ms_rdata_reg;

    // free list
    fifo_ctrl_t        fctrl;
    fifo_stat_t        fstat;
    logic [ID_W-1:0]   fifo_pop_id;

    eidm_free_fifo #(
        .CAPACITY (CAPACITY)
    ) u_free_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (fctrl),
        .push_id (entity),
        .pop_id  (fifo_pop_id),
        .stat    (fstat)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    // an id is live only below the issued count; ids at or past capacity never are
    assign id_ok  = ({1'b0, entity} < (ID_W + 1)'(issued_count_reg));
    // every read issued and the last compare done
    assign scan_done = !chk_valid_reg && (rd_idx_reg == issued_count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        K_CREATE: if (!fstat.empty) state_next = S_POP;
                        K_READ:   if (id_ok) state_next = S_READ;
                        K_QUERY:  state_next = S_SCAN;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_POP:   state_next = S_IDLE;
            S_READ:  state_next = S_IDLE;
            S_SCAN:  if (scan_done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, memory controls and output word
    always_comb
    begin
        issued_count_next = issued_count_reg;
        req_id_next       = req_id_reg;
        req_mask_next     = req_mask_reg;
        rd_idx_next       = rd_idx_reg;
        chk_valid_next    = 1'b0;
        chk_idx_next      = chk_idx_reg;
        pend_valid_next   = pend_valid_reg;
        pend_id_next      = pend_id_reg;

        strobe_next = 1'b0;
        oid_next    = oid_reg;
        omask_next  = '0;
        ostat_next  = ostat_reg;
        olast_next  = 1'b1;

        ms_we    = 1'b0;
        ms_waddr = entity[IDX_W-1:0];
        ms_wdata = '0;
        ms_re    = 1'b0;
        ms_raddr = entity[IDX_W-1:0];

        fctrl = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        K_CREATE:
                        begin
                            if (!fstat.empty)
                                fctrl.pop = 1'b1;
                            else if (issued_count_reg != CNT_W'(CAPACITY))
                            begin
                                // fresh id: its mask starts cleared
                                ms_we             = 1'b1;
                                ms_waddr          = issued_count_reg[IDX_W-1:0];
                                issued_count_next = issued_count_reg + CNT_W'(1);
                                strobe_next       = 1'b1;
                                oid_next          = ID_W'(issued_count_reg);
                                ostat_next        = ST_OK;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                oid_next    = '0;
                                ostat_next  = ST_FULL;
                            end
                        end
                        K_DESTROY:
                        begin
                            strobe_next = 1'b1;
                            oid_next    = entity;
                            if (!id_ok)
                                ostat_next = ST_BAD;
                            else if (fstat.full)
                                ostat_next = ST_QFULL;
                            else
                            begin
                                ms_we      = 1'b1;
                                fctrl.push = 1'b1;
                                ostat_next = ST_OK;
                            end
                        end
                        K_WRITE:
                        begin
                            strobe_next = 1'b1;
                            oid_next    = entity;
                            if (!id_ok)
                                ostat_next = ST_BAD;
                            else
                            begin
                                ms_we      = 1'b1;
                                ms_wdata   = mask[MASK_BITS-1:0];
                                ostat_next = ST_OK;
                            end
                        end
                        K_READ:
                        begin
                            if (!id_ok)
                            begin
                                strobe_next = 1'b1;
                                oid_next    = entity;
                                ostat_next  = ST_BAD;
                            end
                            else
                            begin
                                ms_re       = 1'b1;
                                req_id_next = entity;
                            end
                        end
                        K_QUERY:
                        begin
                            req_mask_next   = mask[MASK_BITS-1:0];
                            rd_idx_next     = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            // unknown kinds are dropped silently
                        end
                    endcase
                end
            end
            S_POP:
            begin
                strobe_next = 1'b1;
                oid_next    = fifo_pop_id;
                ostat_next  = ST_OK;
            end
            S_READ:
            begin
                strobe_next = 1'b1;
                oid_next    = req_id_reg;
                omask_next  = MASK_W'(ms_rdata_reg);
                ostat_next  = ST_OK;
            end
            S_SCAN:
            begin
                // issue one read per cycle in ascending id order
                if (rd_idx_reg < issued_count_reg)
                begin
                    ms_re          = 1'b1;
                    ms_raddr       = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg[IDX_W-1:0];
                end
                // a new match releases the previous one, which is then known not to be last
                if (chk_valid_reg && ((ms_rdata_reg & req_mask_reg) == req_mask_reg))
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        oid_next    = ID_W'(pend_id_reg);
                        ostat_next  = ST_OK;
                        olast_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = chk_idx_reg;
                end
                // scan over: flush the held match as last, or report no match
                if (scan_done)
                begin
                    strobe_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        oid_next   = ID_W'(pend_id_reg);
                        ostat_next = ST_OK;
                    end
                    else
                    begin
                        oid_next   = '0;
                        ostat_next = ST_NOMATCH;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issued_count_reg <= '0;
            chk_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issued_count_reg <= issued_count_next;
            chk_valid_reg    <= chk_valid_next;
            pend_valid_reg   <= pend_valid_next;
            strobe_reg       <= strobe_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_id_reg   <= req_id_next;
        req_mask_reg <= req_mask_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        pend_id_reg  <= pend_id_next;
        oid_reg      <= oid_next;
        omask_reg    <= omask_next;
        ostat_reg    <= ostat_next;
        olast_reg    <= olast_next;
    end

    // mask store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ms_we)
            mask_mem[ms_waddr] <= ms_wdata;
        if (ms_re)
            ms_rdata_reg <= mask_mem[ms_raddr];
    end

    assign strobe     = strobe_reg;
    assign entity_id  = oid_reg;
    assign mask_value = omask_reg;
    assign status     = ostat_reg;
    assign last       = olast_reg;

`ifndef ASSERT_OFF
    a_single_cycle_word: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == K_DESTROY || kind == K_WRITE)) |=> (strobe && last))
        else $error("destroy or write gave no word on the next cycle");

    a_nomatch_form: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == ST_NOMATCH) |-> (last && entity_id == '0 && mask_value == '0))
        else $error("malformed no-match word");

    a_issued_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issued_count_reg <= CNT_W'(CAPACITY))
        else $error("issued count beyond capacity");
`endif

endmodule

`default_nettype wire

>>> tb/sv/eidm_result_checker.sv
`timescale 1ns / 1ps
// result checker for the entity id allocator: tracks ids, free list and masks,
// predicts the words of each accepted request and compares them in order; needs eidm_pkg
module eidm_result_checker
    import eidm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [ID_W-1:0]     entity,
    input  wire logic [MASK_W-1:0]   mask,
    input  wire logic                strobe,
    input  wire logic [ID_W-1:0]     entity_id,
    input  wire logic [MASK_W-1:0]   mask_value,
    input  wire logic [STATUS_W-1:0] status,
    input  wire logic                last,
    output int                       fail_count,
    output int                       pending,
    output int                       words_checked
);

    localparam int SLOTS = 64;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [MASK_W-1:0] mask_value;
        status_t           status;
        logic              last;
    } id_word_t;

    logic [MASK_W-1:0] comp_masks [SLOTS];
    logic [ID_W-1:0]   freed_ids [SLOTS];
    int unsigned       freed_rd;
    int unsigned       freed_wr;
    int unsigned       freed_count;
    int unsigned       issued;
    id_word_t          awaited_words [$];
    int                mismatches = 0;
    int                seen = 0;

    function automatic id_word_t make_word(input logic [ID_W-1:0] id,
                                           input logic [MASK_W-1:0] mv,
                                           input status_t st, input logic fin);
        id_word_t w;
        w.id         = id;
        w.mask_value = mv;
        w.status     = st;
        w.last       = fin;
        return w;
    endfunction

    // append one expected word at the tail of the queue
    function automatic void await_word(input id_word_t w);
        awaited_words.insert(awaited_words.size(), w);
    endfunction

    // one request against the tracked table, expected words appended in order
    task automatic apply_request(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] ent,
                                 input logic [MASK_W-1:0] req);
        bit known;
        int hits;
        known = ent < issued;
        hits  = 0;
        case (k)
            K_CREATE:
            begin
                if (freed_count > 0)
                begin
                    await_word(make_word(freed_ids[freed_rd], '0, ST_OK, 1'b1));
                    freed_rd    = (freed_rd + 1) % SLOTS;
                    freed_count = freed_count - 1;
                end
                else if (issued < SLOTS)
                begin
                    comp_masks[issued] = '0;
                    await_word(make_word(ID_W'(issued), '0, ST_OK, 1'b1));
                    issued = issued + 1;
                end
                else
                    await_word(make_word('0, '0, ST_FULL, 1'b1));
            end
            K_DESTROY:
            begin
                if (!known)
                    await_word(make_word(ent, '0, ST_BAD, 1'b1));
                else if (freed_count >= SLOTS)
                    await_word(make_word(ent, '0, ST_QFULL, 1'b1));
                else
                begin
                    comp_masks[ent]     = '0;
                    freed_ids[freed_wr] = ent;
                    freed_wr            = (freed_wr + 1) % SLOTS;
                    freed_count         = freed_count + 1;
                    await_word(make_word(ent, '0, ST_OK, 1'b1));
                end
            end
            K_WRITE:
            begin
                if (known)
                    comp_masks[ent] = req;
                await_word(make_word(ent, '0, known ? ST_OK : ST_BAD, 1'b1));
            end
            K_READ:
            begin
                if (known)
                    await_word(make_word(ent, comp_masks[ent], ST_OK, 1'b1));
                else
                    await_word(make_word(ent, '0, ST_BAD, 1'b1));
            end
            K_QUERY:
            begin
                for (int i = 0; i < int'(issued); i++)
                begin
                    if ((comp_masks[i] & req) == req)
                    begin
                        await_word(make_word(ID_W'(i), '0, ST_OK, 1'b0));
                        hits++;
                    end
                end
                if (hits == 0)
                    await_word(make_word('0, '0, ST_NOMATCH, 1'b1));
                else
                    awaited_words[awaited_words.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_word();
        id_word_t exp;
        seen++;
        if (awaited_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected word id %0d mask %h status %0d last %b",
                         $realtime, entity_id, mask_value, status, last);
        end
        else
        begin
            exp = awaited_words.pop_front();
            if (entity_id !== exp.id || mask_value !== exp.mask_value ||
                status !== exp.status || last !== exp.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: word %0d expected id %0d mask %h status %0d last %b, got id %0d mask %h status %0d last %b",
                             $realtime, seen, exp.id, exp.mask_value, exp.status, exp.last,
                             entity_id, mask_value, status, last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            freed_rd    = 0;
            freed_wr    = 0;
            freed_count = 0;
            issued      = 0;
            awaited_words.delete();
        end
        else
        begin
            // result first: it belongs to an earlier request than any accepted now
            if (strobe)
                check_word();
            if (start && !busy)
                apply_request(kind, entity, mask);
        end
        fail_count    <= mismatches;
        pending       <= awaited_words.size();
        words_checked <= seen;
    end

endmodule

>>> tb/sv/tb_entity_id_allocator_mask_query.sv
`timescale 1ns / 1ps
// top of the entity id allocator bench: clock, reset, request stimulus and verdict
// needs eidm_pkg, entity_id_allocator_mask_query and eidm_result_checker
module tb_entity_id_allocator_mask_query;
    import eidm_pkg::*;

    // the cycle limit is well above the slowest run
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ID_SLOTS     = 64;

    logic                clk    = 1'b0;
    logic                rst_n  = 1'b0;
    logic                start  = 1'b0;
    logic [KIND_W-1:0]   kind   = K_CREATE;
    logic [ID_W-1:0]     entity = '0;
    logic [MASK_W-1:0]   mask   = '0;
    logic                busy;
    logic                strobe;
    logic [ID_W-1:0]     entity_id;
    logic [MASK_W-1:0]   mask_value;
    logic [STATUS_W-1:0] status;
    logic                last;

    int fail_count;
    int pending;
    int words_checked;
    int cycles        = 0;
    int requests_sent = 0;
    int queries_sent  = 0;
    // upper bound on issued ids, only used to steer entity picks towards live ids
    int ids_handed    = 0;
    // stretch with no idle cycles between words
    bit quiet         = 1'b0;

    always #1 clk = ~clk;

    entity_id_allocator_mask_query DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .entity     (entity),
        .mask       (mask),
        .strobe     (strobe),
        .entity_id  (entity_id),
        .mask_value (mask_value),
        .status     (status),
        .last       (last)
    );

    eidm_result_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .entity        (entity),
        .mask          (mask),
        .strobe        (strobe),
        .entity_id     (entity_id),
        .mask_value    (mask_value),
        .status        (status),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_entity_id_allocator_mask_query NOT OK");
            $finish;
        end
    end

    // drive one request word at a falling edge after a random idle gap, hold it until taken
    task automatic send_word(input kind_t k, input logic [ID_W-1:0] e,
                             input logic [MASK_W-1:0] m);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start  <= 1'b1;
        kind   <= k;
        entity <= e;
        mask   <= m;
        // taken at the rising edge where busy was low
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
        if (k == K_QUERY)
            queries_sent++;
        if (k == K_CREATE && ids_handed < ID_SLOTS)
            ids_handed++;
        if (requests_sent % 25 == 0)
            quiet = ($urandom_range(0, 2) == 0);
    endtask

    function automatic logic [MASK_W-1:0] random_mask();
        return {$urandom, $urandom};
    endfunction

    // mostly live ids, sometimes anything in range
    function automatic logic [ID_W-1:0] pick_entity();
        if (ids_handed > 0 && $urandom_range(0, 4) != 0)
            return ID_W'($urandom_range(0, ids_handed - 1));
        return ID_W'($urandom_range(0, ID_SLOTS - 1));
    endfunction

    // query masks: empty, full, or one to three required bits so a fair share matches
    function automatic logic [MASK_W-1:0] query_bits();
        logic [MASK_W-1:0] m;
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        m = '0;
        repeat ($urandom_range(1, 3))
            m[$urandom_range(0, MASK_W - 1)] = 1'b1;
        return m;
    endfunction

    task automatic random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            send_word(K_CREATE, ID_W'($urandom), random_mask());
        else if (r < 35)
            send_word(K_DESTROY, pick_entity(), random_mask());
        else if (r < 60)
            send_word(K_WRITE, pick_entity(), random_mask());
        else if (r < 80)
            send_word(K_READ, pick_entity(), random_mask());
        else
            send_word(K_QUERY, ID_W'($urandom), query_bits());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table: every access is a bad entity, a query finds nothing
        send_word(K_READ, 6'd0, '0);
        send_word(K_DESTROY, 6'd63, '1);
        send_word(K_WRITE, 6'd5, '1);
        send_word(K_QUERY, 6'd0, '0);
        // fresh ids 0..2 with extreme and patterned masks
        send_word(K_CREATE, 6'd63, '1);
        send_word(K_CREATE, 6'd0, '0);
        send_word(K_CREATE, 6'd21, 64'h5555_5555_5555_5555);
        send_word(K_WRITE, 6'd0, '1);
        send_word(K_WRITE, 6'd1, 64'hA5A5_5A5A_0F0F_F0F0);
        send_word(K_WRITE, 6'd2, '0);
        send_word(K_READ, 6'd0, '0);
        send_word(K_READ, 6'd1, '1);
        send_word(K_READ, 6'd2, '0);
        // empty mask matches all, full mask only id 0, edge bits only id 0
        send_word(K_QUERY, 6'd0, '0);
        send_word(K_QUERY, 6'd63, '1);
        send_word(K_QUERY, 6'd0, 64'h8000_0000_0000_0001);
        send_word(K_QUERY, 6'd0, 64'h0000_0000_0000_0F00);
        // repeated destroy queues the id twice, two creates hand it out twice
        send_word(K_DESTROY, 6'd1, '0);
        send_word(K_DESTROY, 6'd1, '1);
        send_word(K_CREATE, 6'd0, '0);
        send_word(K_CREATE, 6'd0, '0);
        send_word(K_READ, 6'd1, '0);
        send_word(K_READ, 6'd63, '0);
        send_word(K_CREATE, 6'd0, '0);

        repeat (90) random_word();

        // drain the free list and issue every id, the tail end hits table full
        repeat (134) send_word(K_CREATE, ID_W'($urandom), random_mask());
        send_word(K_WRITE, 6'd63, '1);
        send_word(K_READ, 6'd63, '0);
        send_word(K_QUERY, 6'd0, '1);
        send_word(K_QUERY, 6'd0, '0);

        // every id is live now: fill the free list until it overflows
        repeat (70) send_word(K_DESTROY, ID_W'($urandom_range(0, ID_SLOTS - 1)), random_mask());

        repeat (50) random_word();

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d requests including %0d queries, %0d result words checked",
                 requests_sent, queries_sent, words_checked);
        $display("table filled to capacity, free list overflowed, %0d mismatches", fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_entity_id_allocator_mask_query OK");
        else
            $display("tb_entity_id_allocator_mask_query NOT OK");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/eidm_pkg.sv
hw/rtl/eidm_free_fifo.sv
hw/rtl/entity_id_allocator_mask_query.sv
tb/sv/eidm_result_checker.sv
tb/sv/tb_entity_id_allocator_mask_query.sv
